/* src/gpse_pkg.sv */
package gpse_pkg;

    localparam int MAX_LOW_PEAKS   = 8;
    localparam int MAX_MID_PEAKS   = 8;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int EXP_AW    = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int LOW_AW    = (MAX_LOW_PEAKS > 1) ? $clog2(MAX_LOW_PEAKS) : 1;
    localparam int MID_AW    = (MAX_MID_PEAKS > 1) ? $clog2(MAX_MID_PEAKS) : 1;
    localparam int MAX_PEAKS = (MAX_LOW_PEAKS > MAX_MID_PEAKS) ? MAX_LOW_PEAKS : MAX_MID_PEAKS;
    localparam int CNT_W     = ($clog2(MAX_PEAKS + 1) > 4) ? $clog2(MAX_PEAKS + 1) : 4;

    // divider geometry
    localparam int DVD_W  = 80;
    localparam int DSR_W  = 40;
    localparam int STEP_W = 7;
    // mid-term index dividend: d^2 (34 bits) times the table depth
    localparam int IDXN_W = 34 + $clog2(EXP_TABLE_DEPTH) + 1;
    localparam int KDVD_W = 32;

    localparam logic [14:0] INV_SQRT_2PI = 15'd26145;

    localparam logic [1:0] CFG_LOW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_MID_COUNT   = 2'd1;
    localparam logic [1:0] CFG_NORM_TARGET = 2'd2;

    localparam logic [1:0] KIND_LOW  = 2'd0;
    localparam logic [1:0] KIND_MID  = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SAT       = 2'd1,
        ST_NORM_ZERO = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_LRD, S_LP, S_LP2, S_LE, S_LK, S_LA, S_LS,
        S_MRD, S_MS, S_MW, S_MD, S_MI, S_MIW, S_MK, S_MKW, S_MX,
        S_FIN, S_FH, S_FDIV, S_FW, S_DONE
    } t_seq_state;

    typedef logic [16:0] t_exp_rom [EXP_TABLE_DEPTH];

    typedef struct packed {
        logic [3:0]  low_cnt;
        logic [3:0]  mid_cnt;
        logic [15:0] norm_target;
    } t_cfg;

    typedef struct packed {
        logic        low_we;
        logic        mid_we;
        logic [2:0]  index;
        logic [15:0] amp;
        logic [15:0] width;
        logic [15:0] pos;
    } t_load_req;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic        idle;
        logic        res_valid;
        logic [31:0] sigma;
        t_status     status;
    } t_seq_stat;

    // Taylor terms of e^(-16 / depth) in Q40
    localparam logic [63:0] EXP_DEN = 64'(EXP_TABLE_DEPTH);
    localparam logic [63:0] EXP_T0  = 64'd1 << 40;
    localparam logic [63:0] EXP_T1  = (EXP_T0 * 64'd16) / (EXP_DEN * 64'd1);
    localparam logic [63:0] EXP_T2  = (EXP_T1 * 64'd16) / (EXP_DEN * 64'd2);
    localparam logic [63:0] EXP_T3  = (EXP_T2 * 64'd16) / (EXP_DEN * 64'd3);
    localparam logic [63:0] EXP_T4  = (EXP_T3 * 64'd16) / (EXP_DEN * 64'd4);
    localparam logic [63:0] EXP_T5  = (EXP_T4 * 64'd16) / (EXP_DEN * 64'd5);
    localparam logic [63:0] EXP_T6  = (EXP_T5 * 64'd16) / (EXP_DEN * 64'd6);
    localparam logic [63:0] EXP_T7  = (EXP_T6 * 64'd16) / (EXP_DEN * 64'd7);
    localparam logic [63:0] EXP_T8  = (EXP_T7 * 64'd16) / (EXP_DEN * 64'd8);
    localparam logic [63:0] EXP_T9  = (EXP_T8 * 64'd16) / (EXP_DEN * 64'd9);
    localparam logic [63:0] EXP_T10 = (EXP_T9 * 64'd16) / (EXP_DEN * 64'd10);
    localparam logic [63:0] EXP_T11 = (EXP_T10 * 64'd16) / (EXP_DEN * 64'd11);
    localparam logic [63:0] EXP_T12 = (EXP_T11 * 64'd16) / (EXP_DEN * 64'd12);
    localparam logic [63:0] EXP_ACC = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                                    + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
                                    - EXP_T11 + EXP_T12;
    localparam logic [63:0] EXP_RATIO = EXP_ACC >> 10;

    // e^(-16 i / depth) in Q16, built by repeated multiplication with a Q30 ratio
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] v;
        v = 64'd1 << 30;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            rom[i] = 17'((v + 64'd8192) >> 14);
            v = (v * EXP_RATIO) >> 30;
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

/* src/gaussian_peak_sum_evaluator.sv */
// Gaussian peak sum evaluator. Load requests (kind 0 low peak, kind 1 mid peak) write one
// table entry; kind 3 is dropped. An evaluate request walks the low peaks and the mid
// peaks (two Gaussian terms each, each term needing a table-index and a scale division on
// the shared one-bit-per-cycle divider; a zero-width peak skips both), then scales by
// norm_target / N with an 80-step division. Requests are taken only while no evaluation
// is running; a finished result sits in the output register so the next request can
// enter while it waits.
module gaussian_peak_sum_evaluator
    import gpse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_peak_index,
    input  logic [15:0] i_amplitude,
    input  logic [15:0] i_peak_width,
    input  logic [15:0] i_peak_position,
    input  logic [15:0] i_omega,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sigma,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_out_valid;
    logic [31:0] r_sigma;
    logic [1:0]  r_status;

    t_load_req   load;
    t_seq_stat   stat;
    logic        in_acc;
    logic        res_take;

    assign in_acc   = i_in_valid && o_in_ready;
    assign res_take = stat.res_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        load.low_we = in_acc && (i_kind == KIND_LOW)
                    && (32'(i_peak_index) < 32'(MAX_LOW_PEAKS));
        load.mid_we = in_acc && (i_kind == KIND_MID)
                    && (32'(i_peak_index) < 32'(MAX_MID_PEAKS));
        load.index  = i_peak_index;
        load.amp    = i_amplitude;
        load.width  = i_peak_width;
        load.pos    = i_peak_position;
    end

    gpse_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_load     (load),
        .i_start    (in_acc && (i_kind == KIND_EVAL)),
        .i_omega    (i_omega),
        .i_res_take (res_take),
        .o_stat     (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_cnt     <= 4'd0;
            r_cfg.mid_cnt     <= 4'd0;
            r_cfg.norm_target <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW_COUNT:   r_cfg.low_cnt     <= i_cfg_data[3:0];
                CFG_MID_COUNT:   r_cfg.mid_cnt     <= i_cfg_data[3:0];
                CFG_NORM_TARGET: r_cfg.norm_target <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_sigma  <= stat.sigma;
            r_status <= stat.status;
        end
    end

    assign o_in_ready  = stat.idle;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sigma     = r_sigma;
    assign o_status    = r_status;

endmodule

/* src/gpse_div.sv */
module gpse_div
    import gpse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DSR_W:0]    r_rem;
    logic [DSR_W-1:0]  r_dsr;

    logic [DSR_W:0]    rem_sh;
    logic              q_bit;

    // one quotient bit per cycle; quotient bits shift in behind the dividend
    always_comb begin
        rem_sh = {r_rem[DSR_W-1:0], r_dvd[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

/* src/gpse_seq.sv */
module gpse_seq
    import gpse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_load_req   i_load,
    input  logic        i_start,
    input  logic [15:0] i_omega,
    input  logic        i_res_take,
    output t_seq_stat   o_stat
);

    logic [31:0] low_mem [MAX_LOW_PEAKS];
    logic [47:0] mid_mem [MAX_MID_PEAKS];

    t_seq_state r_state, n_state;

    logic [CNT_W-1:0] r_i;
    logic [15:0]      r_omega;
    logic [31:0]      r_low_q;
    logic [47:0]      r_mid_q;
    logic [31:0]      r_p;
    logic [63:0]      r_prod;
    logic [23:0]      r_k;
    logic [31:0]      r_a2;
    logic [31:0]      r_w2;
    logic             r_pass;
    logic [63:0]      r_sum;
    logic [36:0]      r_norm;
    logic [79:0]      r_x;
    logic [31:0]      r_sigma;
    t_status          r_status;

    logic [CNT_W-1:0] nl, nm;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [16:0]      d;
    logic [63:0]      idx_low;
    logic [16:0]      e_low, e_mid;
    logic [IDXN_W-1:0] dd_scaled;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    wire [15:0] l_amp = r_low_q[31:16];
    wire [15:0] l_rate = r_low_q[15:0];
    wire [15:0] m_str = r_mid_q[47:32];
    wire [15:0] m_wid = r_mid_q[31:16];
    wire [15:0] m_pos = r_mid_q[15:0];

    // peak tables, one synchronous read port each
    always_ff @(posedge i_clk) begin
        if (i_load.low_we) begin
            low_mem[LOW_AW'(i_load.index)] <= {i_load.amp, i_load.width};
        end
        r_low_q <= low_mem[r_i[LOW_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_load.mid_we) begin
            mid_mem[MID_AW'(i_load.index)] <= {i_load.amp, i_load.width, i_load.pos};
        end
        r_mid_q <= mid_mem[r_i[MID_AW-1:0]];
    end

    gpse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        nl = (CNT_W'(i_cfg.low_cnt) > CNT_W'(MAX_LOW_PEAKS)) ? CNT_W'(MAX_LOW_PEAKS)
                                                             : CNT_W'(i_cfg.low_cnt);
        nm = (CNT_W'(i_cfg.mid_cnt) > CNT_W'(MAX_MID_PEAKS)) ? CNT_W'(MAX_MID_PEAKS)
                                                             : CNT_W'(i_cfg.mid_cnt);
        d = r_pass ? (17'(r_omega) + 17'(m_pos))
                   : ((r_omega >= m_pos) ? 17'(r_omega - m_pos) : 17'(m_pos - r_omega));
        idx_low = (64'(r_prod[37:0]) * 64'(EXP_TABLE_DEPTH)) >> 37;
        e_low = ((r_p < 32'h0008_0000) && (idx_low < 64'(EXP_TABLE_DEPTH)))
              ? EXP_ROM[idx_low[EXP_AW-1:0]] : 17'd0;
        e_mid = (div_rsp.quotient < DVD_W'(EXP_TABLE_DEPTH))
              ? EXP_ROM[div_rsp.quotient[EXP_AW-1:0]] : 17'd0;
        dd_scaled = IDXN_W'(64'(r_prod[33:0]) * 64'(EXP_TABLE_DEPTH));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_LRD;
            S_LRD:   n_state = (r_i < nl) ? S_LP : S_MRD;
            S_LP:    n_state = S_LP2;
            S_LP2:   n_state = S_LE;
            S_LE:    n_state = S_LK;
            S_LK:    n_state = S_LA;
            S_LA:    n_state = S_LS;
            S_LS:    n_state = S_LRD;
            S_MRD:   n_state = (r_i < nm) ? S_MS : S_FIN;
            S_MS:    n_state = S_MW;
            S_MW:    n_state = (m_wid == 16'd0) ? S_MRD : S_MD;
            S_MD:    n_state = S_MI;
            S_MI:    n_state = S_MIW;
            S_MIW:   if (div_rsp.done) n_state = S_MK;
            S_MK:    n_state = S_MKW;
            S_MKW:   if (div_rsp.done) n_state = S_MX;
            S_MX:    n_state = r_pass ? S_MRD : S_MD;
            S_FIN:   n_state = ((r_norm == '0) || (i_cfg.norm_target == 16'd0)) ? S_DONE : S_FH;
            S_FH:    n_state = S_FDIV;
            S_FDIV:  n_state = S_FW;
            S_FW:    if (div_rsp.done) n_state = S_DONE;
            S_DONE:  if (i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // shared multiplier operands and divider requests
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_req = '0;
        unique case (r_state)
            S_LP:  begin mul_a = 32'(r_omega);     mul_b = 32'(l_rate); end
            S_LP2: begin mul_a = 32'(r_p[18:0]);   mul_b = 32'(r_p[18:0]); end
            S_LE:  begin mul_a = 32'(l_rate);      mul_b = 32'(e_low); end
            S_LK:  begin mul_a = r_prod[31:0];     mul_b = 32'(INV_SQRT_2PI); end
            S_LA:  begin mul_a = 32'(l_amp);       mul_b = 32'(l_amp); end
            S_LS:  begin mul_a = r_a2;             mul_b = 32'(r_k); end
            S_MS:  begin mul_a = 32'(m_str);       mul_b = 32'(m_str); end
            S_MW:  begin mul_a = 32'(m_wid);       mul_b = 32'(m_wid); end
            S_MD:  begin mul_a = 32'(d);           mul_b = 32'(d); end
            S_MIW: begin mul_a = 32'(e_mid);       mul_b = 32'(INV_SQRT_2PI); end
            S_MX:  begin mul_a = r_a2;             mul_b = 32'(r_k); end
            S_FIN: begin mul_a = r_sum[31:0];      mul_b = 32'(i_cfg.norm_target); end
            S_FH:  begin mul_a = r_sum[63:32];     mul_b = 32'(i_cfg.norm_target); end
            S_MI: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(dd_scaled) << (DVD_W - IDXN_W);
                div_req.divisor  = DSR_W'({r_w2, 5'd0});
                div_req.steps    = STEP_W'(IDXN_W);
            end
            S_MK: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(r_prod[KDVD_W-1:0]) << (DVD_W - KDVD_W);
                div_req.divisor  = DSR_W'({m_wid, 8'd0});
                div_req.steps    = STEP_W'(KDVD_W);
            end
            S_FDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_x;
                div_req.divisor  = DSR_W'(r_norm);
                div_req.steps    = STEP_W'(DVD_W);
            end
            default: ;
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_omega <= i_omega;
                    r_sum   <= '0;
                    r_norm  <= '0;
                    r_i     <= '0;
                end
            end
            S_LRD:  if (!(r_i < nl)) r_i <= '0;
            S_LP:   r_p <= mul_p[31:0];
            S_LP2:  r_prod <= mul_p;
            S_LE:   r_prod <= mul_p;
            S_LK:   r_k <= mul_p[47:24];
            S_LA:   r_a2 <= mul_p[31:0];
            S_LS: begin
                r_sum  <= r_sum + mul_p;
                r_norm <= r_norm + 37'(r_a2);
                r_i    <= r_i + 1'b1;
            end
            S_MS:   r_a2 <= mul_p[31:0];
            S_MW: begin
                // a zero-width peak still counts in the normalization
                r_norm <= r_norm + 37'({r_a2, 1'b0});
                r_w2   <= mul_p[31:0];
                r_pass <= 1'b0;
                if (m_wid == 16'd0) r_i <= r_i + 1'b1;
            end
            S_MD:   r_prod <= mul_p;
            S_MIW:  if (div_rsp.done) r_prod <= mul_p;
            S_MKW:  if (div_rsp.done) r_k <= div_rsp.quotient[23:0];
            S_MX: begin
                r_sum  <= r_sum + mul_p;
                r_pass <= 1'b1;
                if (r_pass) r_i <= r_i + 1'b1;
            end
            S_FIN: begin
                r_x     <= 80'(mul_p[47:0]);
                r_sigma <= '0;
                r_status <= (r_norm == '0) ? ST_NORM_ZERO : ST_OK;
            end
            S_FH:   r_x <= (80'(mul_p[47:0]) << 32) + r_x;
            S_FW: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient[79:40] != '0) begin
                        r_sigma  <= 32'hFFFF_FFFF;
                        r_status <= ST_SAT;
                    end else begin
                        r_sigma  <= div_rsp.quotient[39:8];
                        r_status <= ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_stat.sigma     = r_sigma;
    assign o_stat.status    = r_status;

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MIW || r_state == S_MKW || r_state == S_FW))
        else $error("divider finished outside a wait state");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.res_valid && r_status == ST_SAT) |-> (r_sigma == 32'hFFFF_FFFF))
        else $error("saturated result not all ones");

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.res_valid && r_status == ST_NORM_ZERO) |-> (r_sigma == 32'd0))
        else $error("zero normalization with nonzero sigma");

endmodule

/* tb/sv/gaussian_peak_sum_checker.sv */
`timescale 1ns / 100ps

module gaussian_peak_sum_checker
    import gpse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_peak_index,
    input  logic [15:0] i_amplitude,
    input  logic [15:0] i_peak_width,
    input  logic [15:0] i_peak_position,
    input  logic [15:0] i_omega,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_sigma,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] sigma;
        logic [1:0]  status;
    } t_sum_result;

    longint unsigned decay_rom [EXP_TABLE_DEPTH];

    logic [3:0]  low_count;
    logic [3:0]  mid_count;
    logic [15:0] weight_target;
    logic [15:0] amp_tab   [MAX_LOW_PEAKS];
    logic [15:0] rate_tab  [MAX_LOW_PEAKS];
    logic [15:0] str_tab   [MAX_MID_PEAKS];
    logic [15:0] wid_tab   [MAX_MID_PEAKS];
    logic [15:0] pos_tab   [MAX_MID_PEAKS];

    t_sum_result sums_due [$];

    // decay table e^(-16 i / depth) in Q16, grown by a Q30 step ratio
    initial begin
        longint unsigned term;
        longint unsigned acc;
        longint unsigned ratio;
        longint unsigned v;
        term = 64'd1 << 40;
        acc  = 64'd1 << 40;
        for (int n = 1; n <= 12; n++) begin
            term = (term * 16) / (longint'(EXP_TABLE_DEPTH) * n);
            acc = (n & 1) ? acc - term : acc + term;
        end
        ratio = acc >> 10;
        v = 64'd1 << 30;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            decay_rom[i] = (v + 64'd8192) >> 14;
            v = (v * ratio) >> 30;
        end
    end

    function automatic longint unsigned decay(input longint unsigned idx);
        return (idx < EXP_TABLE_DEPTH) ? decay_rom[idx] : 64'd0;
    endfunction

    function automatic longint unsigned mid_weight(input longint unsigned d,
                                                   input longint unsigned wd);
        longint unsigned idx;
        idx = (d * d * EXP_TABLE_DEPTH) / (32 * wd * wd);
        return (decay(idx) * 26145) / (wd * 256);
    endfunction

    function automatic t_sum_result peak_sum(input logic [15:0] w);
        t_sum_result     res;
        longint unsigned sum, norm, a, r, p, e, k, s2, wd, c, om, q, rem, total;
        int              nl, nm;
        sum = 0;
        norm = 0;
        om = w;
        nl = (low_count < MAX_LOW_PEAKS) ? low_count : MAX_LOW_PEAKS;
        nm = (mid_count < MAX_MID_PEAKS) ? mid_count : MAX_MID_PEAKS;
        for (int i = 0; i < nl; i++) begin
            a = amp_tab[i];
            r = rate_tab[i];
            p = om * r;
            e = 0;
            if (p < (64'd1 << 19)) e = decay((p * p * EXP_TABLE_DEPTH) >> 37);
            k = (r * e * 26145) >> 24;
            sum += a * a * k;
            norm += a * a;
        end
        for (int i = 0; i < nm; i++) begin
            s2 = longint'(str_tab[i]) * str_tab[i];
            wd = wid_tab[i];
            c = pos_tab[i];
            norm += 2 * s2;
            if (wd != 0) begin
                sum += s2 * mid_weight((om >= c) ? om - c : c - om, wd);
                sum += s2 * mid_weight(om + c, wd);
            end
        end
        res.status = ST_OK;
        if (norm == 0) begin
            res.sigma = 0;
            res.status = ST_NORM_ZERO;
        end else if (weight_target == 0) begin
            res.sigma = 0;
        end else begin
            q = sum / norm;
            rem = sum % norm;
            if (q >= (64'd1 << 40)) begin
                res.sigma = 32'hFFFF_FFFF;
                res.status = ST_SAT;
            end else begin
                total = (q * weight_target + (rem * weight_target) / norm) >> 8;
                if (total > 64'hFFFF_FFFF) begin
                    res.sigma = 32'hFFFF_FFFF;
                    res.status = ST_SAT;
                end else begin
                    res.sigma = total[31:0];
                end
            end
        end
        return res;
    endfunction

    assign o_pending = sums_due.size();

    always @(posedge i_clk) begin
        t_sum_result want;
        if (!i_rst_n) begin
            low_count <= 4'd0;
            mid_count <= 4'd0;
            weight_target <= 16'd256;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOW_COUNT:   low_count <= i_cfg_data[3:0];
                    CFG_MID_COUNT:   mid_count <= i_cfg_data[3:0];
                    CFG_NORM_TARGET: weight_target <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_LOW: begin
                        amp_tab[i_peak_index]  = i_amplitude;
                        rate_tab[i_peak_index] = i_peak_width;
                    end
                    KIND_MID: begin
                        str_tab[i_peak_index] = i_amplitude;
                        wid_tab[i_peak_index] = i_peak_width;
                        pos_tab[i_peak_index] = i_peak_position;
                    end
                    KIND_EVAL: sums_due = {sums_due, peak_sum(i_omega)};
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected result sigma %h status %0d",
                             $time, i_sigma, i_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sums_due.pop_front();
                    if (want.sigma !== i_sigma || want.status !== i_status) begin
                        $display("%0t: sigma expected %h actual %h, status expected %0d actual %0d",
                                 $time, want.sigma, i_sigma, want.status, i_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/gaussian_peak_sum_evaluator_test.sv */
`timescale 1ns / 100ps

module gaussian_peak_sum_evaluator_test;
    import gpse_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam longint RUN_LIMIT = 12_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [2:0]  i_peak_index;
    logic [15:0] i_amplitude;
    logic [15:0] i_peak_width;
    logic [15:0] i_peak_position;
    logic [15:0] i_omega;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_sigma;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int     fail_count;
    int     pending;
    bit     calm;
    int     sink_hold;
    longint cycles;

    gaussian_peak_sum_evaluator u_dut (.*);

    gaussian_peak_sum_checker u_check (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_kind, .i_peak_index, .i_amplitude, .i_peak_width, .i_peak_position, .i_omega,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_sigma(o_sigma), .i_status(o_status),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > RUN_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side backpressure, one random hold per result
    initial begin
        i_out_ready = 1'b0;
        sink_hold = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0 && !calm) begin
                i_out_ready <= 1'b0;
                sink_hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sink_hold = $urandom_range(0, 15);
        end
    end

    // random value whose magnitude is spread over all bit lengths
    function automatic logic [15:0] spread16();
        int bits;
        bits = $urandom_range(0, 16);
        return 16'($urandom & ((32'd1 << bits) - 1));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] kind, input logic [2:0] idx,
                                input logic [15:0] amp, input logic [15:0] wid,
                                input logic [15:0] pos, input logic [15:0] om);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_peak_index    <= idx;
        i_amplitude     <= amp;
        i_peak_width    <= wid;
        i_peak_position <= pos;
        i_omega         <= om;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // drop the request line and wait for the block to drain
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [3:0] lc, input logic [3:0] mc,
                            input logic [15:0] tgt);
        drain();
        write_reg(CFG_LOW_COUNT, 16'(lc));
        write_reg(CFG_MID_COUNT, 16'(mc));
        write_reg(CFG_NORM_TARGET, tgt);
    endtask

    initial begin
        logic [1:0] kind;
        int         pick;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = KIND_LOW;
        i_peak_index    = '0;
        i_amplitude     = '0;
        i_peak_width    = '0;
        i_peak_position = '0;
        i_omega         = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_LOW_COUNT;
        i_cfg_data      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no peaks in use: normalization is zero
        send_request(KIND_EVAL, 3'd0, 16'd0, 16'd0, 16'd0, 16'h0100);
        send_request(KIND_SPARE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_LOW, 3'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_request(KIND_LOW, 3'd1, 16'd0, 16'd1, 16'd0, 16'd0);
        send_request(KIND_MID, 3'd0, 16'h0100, 16'd0, 16'h0200, 16'd0); // zero width
        send_request(KIND_MID, 3'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
        for (int i = 2; i < 8; i++) begin
            send_request(KIND_LOW, 3'(i), spread16(), spread16() | 16'd1, spread16(), 16'd0);
            send_request(KIND_MID, 3'(i), spread16(), spread16(), spread16(), 16'd0);
        end
        set_regs(4'd8, 4'd8, 16'hFFFF);
        send_request(KIND_EVAL, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(KIND_EVAL, 3'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        set_regs(4'd1, 4'd0, 16'd0); // zero target
        send_request(KIND_EVAL, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        set_regs(4'd0, 4'd2, 16'd1);
        send_request(KIND_EVAL, 3'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 1) begin
                set_regs(4'd8, 4'd8, 16'hFFFF);
            end else if (phase == 2) begin
                set_regs(4'd0, 4'd0, 16'd1);
            end else begin
                set_regs(4'($urandom_range(0, 8)),
                         4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8)
                                                       : $urandom_range(0, 2)),
                         ($urandom_range(0, 5) == 0) ? 16'd0 : spread16());
            end
            calm = (phase % 4) == 3;
            for (int n = 0; n < 150; n++) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 45) ? KIND_EVAL : (pick < 70) ? KIND_LOW :
                       (pick < 95) ? KIND_MID : KIND_SPARE;
                send_request(kind, 3'($urandom), spread16(),
                             (kind == KIND_LOW) ? (spread16() | 16'd1) : spread16(),
                             spread16(), spread16());
            end
        end
        calm = 1'b0;
        drain();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
src/gpse_pkg.sv
src/gpse_div.sv
src/gpse_seq.sv
src/gaussian_peak_sum_evaluator.sv
tb/sv/gaussian_peak_sum_checker.sv
tb/sv/gaussian_peak_sum_evaluator_test.sv
